/* hdl/bcdt_pkg.sv */
// Shared types and operation codes for the balancer channel duty timer.
package bcdt_pkg;

	// Item operation codes
	typedef enum logic [0:0] {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Field widths fixed by the item format
	localparam int unsigned CH_W    = 3;
	localparam int unsigned VAL_W   = 8;
	localparam int unsigned DRIVE_W = 8;

	// On-time write into the channel bank
	typedef struct packed {
		logic              en;
		logic [CH_W-1:0]   channel;
		logic [VAL_W-1:0]  on_time;
	} wr_t;

	// Channel bank status toward the control logic
	typedef struct packed {
		logic               any_enabled;
		logic [DRIVE_W-1:0] drive;
	} bank_stat_t;

endpackage

/* hdl/bcdt_chan_bank.sv */
// Per-channel on-time registers, enable bits and duty compares.
module bcdt_chan_bank import bcdt_pkg::*; #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wr_t               wr,
	input  logic [VAL_W-1:0]  count_next,
	output bank_stat_t        stat
);

	logic [CHANNELS-1:0] enable_q;
	logic [VAL_W-1:0]    on_time_q [CHANNELS];
	logic [DRIVE_W-1:0]  drive;

	for (genvar n = 0; n < DRIVE_W; n++) begin : g_ch
		if (n < CHANNELS) begin : g_used
			logic hit;
			assign hit = wr.en && (wr.channel == CH_W'(n));

			// enable follows nonzero on-time
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					enable_q[n] <= 1'b0;
				end else if (hit) begin
					enable_q[n] <= (wr.on_time != '0);
				end
			end

			// on-time payload, no reset
			always_ff @(posedge clk) begin
				if (hit) begin
					on_time_q[n] <= wr.on_time;
				end
			end

			assign drive[n] = enable_q[n] && (count_next < on_time_q[n]);
		end else begin : g_unused
			assign drive[n] = 1'b0;
		end
	end

	assign stat.any_enabled = |enable_q;
	assign stat.drive       = drive;

endmodule

/* hdl/bcdt_out_reg.sv */
// Result holding register with valid/stall handshake.
module bcdt_out_reg import bcdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [DRIVE_W-1:0] data,
	output logic               free,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [DRIVE_W-1:0] drive_bits
);

	logic               valid_q;
	logic [DRIVE_W-1:0] data_q;

	// slot can take new data when empty or being taken this cycle
	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= data;
		end
	end

	assign result_valid = valid_q;
	assign drive_bits   = data_q;

endmodule

/* hdl/balancer_channel_duty_timer.sv */
// Top level of the balancer channel duty timer.
// Drives up to CHANNELS passive balancer switches from one shared 8-bit tick
// counter. A set transaction stores a channel's on-time (zero disables the
// channel, channels at or beyond CHANNELS are ignored); a tick transaction
// advances the counter when any channel is enabled and emits the new drive
// byte only when it differs from the last byte sent. One transaction is taken
// every cycle; an item enters an input register, is processed against the
// counter and channel registers once the output register is free, and its
// result, if any, is then registered in the output register. Throughput drops
// only while the output register holds a result that the receiver stalls.
module balancer_channel_duty_timer import bcdt_pkg::*; #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [0:0]         operation,
	input  logic [CH_W-1:0]    channel,
	input  logic [VAL_W-1:0]   on_time,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [DRIVE_W-1:0] drive_bits
);

	logic               valid_s1;
	op_t                op_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [VAL_W-1:0]   val_s1;
	logic [VAL_W-1:0]   count_q;
	logic [DRIVE_W-1:0] last_q;
	logic [VAL_W-1:0]   count_next;
	logic               free;
	logic               go;
	logic               tick_go;
	logic               emit;
	wr_t                wr;
	bank_stat_t         stat;

	// input stage holds while its item cannot be processed
	assign item_stall = valid_s1 && !free;
	assign go         = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1  <= op_t'(operation);
			ch_s1  <= channel;
			val_s1 <= on_time;
		end
	end

	// set transaction writes the channel bank
	assign wr.en      = go && (op_s1 == OP_SET);
	assign wr.channel = ch_s1;
	assign wr.on_time = val_s1;

	assign count_next = count_q + VAL_W'(1);

	bcdt_chan_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.count_next (count_next),
		.stat       (stat)
	);

	// tick advances counter only with a channel enabled
	assign tick_go = go && (op_s1 == OP_TICK) && stat.any_enabled;
	assign emit    = tick_go && (stat.drive != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
		end else begin
			if (tick_go) begin
				count_q <= count_next;
			end
			if (emit) begin
				last_q <= stat.drive;
			end
		end
	end

	bcdt_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (emit),
		.data         (stat.drive),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.drive_bits   (drive_bits)
	);

endmodule
